// File: design/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Shared types, constants and helpers of the HSV to RGB converter pipeline.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned IN_W      = FRAC_BITS + 1;
  localparam int unsigned PROD_W    = 2 * IN_W;

  localparam logic [IN_W-1:0] FX_ONE = IN_W'(1) << FRAC_BITS;

  // hue sectors, sixths of a turn
  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;

  typedef struct packed {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] saturation;
    logic [IN_W-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [2:0]           sector;
    logic                 grey;
    logic [IN_W-1:0]      sat;
    logic [IN_W-1:0]      val;
    logic [FRAC_BITS-1:0] ff;
    logic [IN_W-1:0]      one_minus_ff;
    logic [IN_W-1:0]      one_minus_s;
  } front_t;

  typedef struct packed {
    logic [2:0]      sector;
    logic            grey;
    logic [IN_W-1:0] val;
    logic [IN_W-1:0] p;
    logic [IN_W-1:0] kq;
    logic [IN_W-1:0] kt;
  } scale_t;

  typedef struct packed {
    logic [2:0]      sector;
    logic            grey;
    logic [IN_W-1:0] val;
    logic [IN_W-1:0] p;
    logic [IN_W-1:0] q;
    logic [IN_W-1:0] t;
  } chan_t;

  // product of two fractions, truncated back to the fraction grid
  function automatic logic [IN_W-1:0] fx_mul(input logic [IN_W-1:0] a,
                                             input logic [IN_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(a) * PROD_W'(b);
    return prod[FRAC_BITS +: IN_W];
  endfunction

  // floor(255 * x) for a fraction x in [0, 1]
  function automatic logic [7:0] to_byte(input logic [IN_W-1:0] x);
    logic [IN_W+7:0] prod;
    prod = {x, 8'h00} - (IN_W+8)'(x);
    return prod[FRAC_BITS +: 8];
  endfunction

endpackage

// File: design/hsvrgb_front.sv
// ----------------------------------------------------------------------------
// hsvrgb_front
// Input stage: saturates the beat, takes a hue of one or more to zero and splits it
// into sector and fraction.
// ----------------------------------------------------------------------------
module hsvrgb_front import hsvrgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  hsv_t   hsv_i,
  output logic   valid_o,
  output front_t front_o
);

  logic [FRAC_BITS-1:0] hue;
  logic [FRAC_BITS+2:0] hue6;
  logic [IN_W-1:0]      sat;
  logic [IN_W-1:0]      val;
  front_t               front_d, front_q;
  logic                 valid_q;

  always_comb begin
    hue  = (hsv_i.hue >= FX_ONE) ? '0 : hsv_i.hue[FRAC_BITS-1:0];
    sat  = (hsv_i.saturation > FX_ONE) ? FX_ONE : hsv_i.saturation;
    val  = (hsv_i.brightness > FX_ONE) ? FX_ONE : hsv_i.brightness;
    hue6 = ((FRAC_BITS+3)'(hue) << 2) + ((FRAC_BITS+3)'(hue) << 1);

    front_d.sector       = hue6[FRAC_BITS +: 3];
    front_d.grey         = (sat == '0);
    front_d.sat          = sat;
    front_d.val          = val;
    front_d.ff           = hue6[FRAC_BITS-1:0];
    front_d.one_minus_ff = FX_ONE - IN_W'(hue6[FRAC_BITS-1:0]);
    front_d.one_minus_s  = FX_ONE - sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
  end

  assign valid_o = valid_q;
  assign front_o = front_q;

endmodule

// File: design/hsvrgb_mul.sv
// ----------------------------------------------------------------------------
// hsvrgb_mul
// Two multiply stages: s*ff, s*(1-ff) and p, then q and t from the value.
// ----------------------------------------------------------------------------
module hsvrgb_mul import hsvrgb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  input  front_t front_i,
  output logic   valid_o,
  output chan_t  chan_o
);

  scale_t scale_d, scale_q;
  chan_t  chan_d, chan_q;
  logic   valid1_q, valid2_q;

  always_comb begin
    scale_d.sector = front_i.sector;
    scale_d.grey   = front_i.grey;
    scale_d.val    = front_i.val;
    scale_d.p      = fx_mul(front_i.val, front_i.one_minus_s);
    scale_d.kq     = FX_ONE - fx_mul(front_i.sat, IN_W'(front_i.ff));
    scale_d.kt     = FX_ONE - fx_mul(front_i.sat, front_i.one_minus_ff);
  end

  always_comb begin
    chan_d.sector = scale_q.sector;
    chan_d.grey   = scale_q.grey;
    chan_d.val    = scale_q.val;
    chan_d.p      = scale_q.p;
    chan_d.q      = fx_mul(scale_q.val, scale_q.kq);
    chan_d.t      = fx_mul(scale_q.val, scale_q.kt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    scale_q <= scale_d;
    chan_q  <= chan_d;
  end

  assign valid_o = valid2_q;
  assign chan_o  = chan_q;

endmodule

// File: design/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// hsvrgb_mix
// Output stage: picks the channel permutation of the sector, or the value on all
// channels for grey, and scales each channel to a byte.
// ----------------------------------------------------------------------------
module hsvrgb_mix import hsvrgb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  chan_t chan_i,
  output logic  valid_o,
  output rgb_t  rgb_o
);

  logic [IN_W-1:0] r, g, b;
  rgb_t            rgb_d, rgb_q;
  logic            valid_q;

  always_comb begin
    case (chan_i.sector)
      SEC_RED: begin
        r = chan_i.val; g = chan_i.t;   b = chan_i.p;
      end
      SEC_YELLOW: begin
        r = chan_i.q;   g = chan_i.val; b = chan_i.p;
      end
      SEC_GREEN: begin
        r = chan_i.p;   g = chan_i.val; b = chan_i.t;
      end
      SEC_CYAN: begin
        r = chan_i.p;   g = chan_i.q;   b = chan_i.val;
      end
      SEC_BLUE: begin
        r = chan_i.t;   g = chan_i.p;   b = chan_i.val;
      end
      default: begin
        r = chan_i.val; g = chan_i.p;   b = chan_i.q;
      end
    endcase
    if (chan_i.grey) begin
      r = chan_i.val;
      g = chan_i.val;
      b = chan_i.val;
    end
    rgb_d.red   = to_byte(r);
    rgb_d.green = to_byte(g);
    rgb_d.blue  = to_byte(b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

// File: design/hsv_to_rgb_converter.sv
// A colour passes the front, scale, channel and mix registers from start_i to done_o.
// Throughput: one colour per clock; four register stages, one beat each.
// busy_o stays low: the pipeline has no stall path and the receiver cannot stall.
// Reset clears the stage valid bits only; no beat is in flight after reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// HSV to 8-bit RGB colour conversion, pipelined over four stages.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter import hsvrgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  hsv_t hsv_i,
  output logic busy_o,
  output logic done_o,
  output rgb_t rgb_o
);

  logic   front_valid;
  front_t front;
  logic   chan_valid;
  chan_t  chan;

  assign busy_o = 1'b0;

  hsvrgb_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .hsv_i   (hsv_i),
    .valid_o (front_valid),
    .front_o (front)
  );

  hsvrgb_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .front_i (front),
    .valid_o (chan_valid),
    .chan_o  (chan)
  );

  hsvrgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chan_valid),
    .chan_i  (chan),
    .valid_o (done_o),
    .rgb_o   (rgb_o)
  );

endmodule

// File: design/hsvrgb_checker.sv
// ----------------------------------------------------------------------------
// hsvrgb_checker
// Port-level checks of the converter: beat timing and grey/black results.
// ----------------------------------------------------------------------------
module hsvrgb_checker import hsvrgb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input hsv_t hsv_i,
  input logic busy_o,
  input logic done_o,
  input rgb_t rgb_o
);

  a_beat_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##4 done_o)
    else $error("accepted beat gave no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 4))
    else $error("result without an accepted beat");

  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(hsv_i.saturation == '0, 4))
      |-> (rgb_o.red == rgb_o.green && rgb_o.green == rgb_o.blue))
    else $error("zero saturation did not give grey");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(hsv_i.brightness == '0, 4)) |-> (rgb_o == '0))
    else $error("zero value did not give black");

endmodule

bind hsv_to_rgb_converter hsvrgb_checker u_hsvrgb_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .hsv_i   (hsv_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rgb_o   (rgb_o)
);

// File: test/hsv_rgb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_rgb_checker
// Watches the command and result channels of the HSV to RGB converter,
// predicts the colour of every accepted beat and compares each result with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module hsv_rgb_checker import hsvrgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  hsv_t hsv_i,
  input  logic busy_i,
  input  logic done_i,
  input  rgb_t rgb_i,
  output int   pending_o,
  output int   fail_count_o
);

  rgb_t rgb_pending[$];
  int   pending_n = 0;
  int   mismatches = 0;

  assign pending_o    = pending_n;
  assign fail_count_o = mismatches;

  function automatic logic [IN_W-1:0] clip_unit(input logic [IN_W-1:0] x);
    return (x > FX_ONE) ? FX_ONE : x;
  endfunction

  function automatic logic [IN_W-1:0] frac_mul(input logic [IN_W-1:0] a,
                                               input logic [IN_W-1:0] b);
    longint unsigned prod;
    prod = longint'(a) * longint'(b);
    return IN_W'(prod >> FRAC_BITS);
  endfunction

  function automatic logic [7:0] scale_255(input logic [IN_W-1:0] x);
    longint unsigned prod;
    prod = 255 * longint'(x);
    return 8'(prod >> FRAC_BITS);
  endfunction

  function automatic rgb_t convert_hsv(input hsv_t c);
    logic [IN_W-1:0]      h, s, v, p, q, t, r, g, b;
    logic [FRAC_BITS-1:0] ff;
    logic [2:0]           sector;
    int unsigned          hh;
    rgb_t                 res;
    h = clip_unit(c.hue);
    s = clip_unit(c.saturation);
    v = clip_unit(c.brightness);
    if (s == '0) begin
      res.red   = scale_255(v);
      res.green = res.red;
      res.blue  = res.red;
      return res;
    end
    if (h == FX_ONE) h = '0;
    hh     = 6 * int'(h);
    sector = 3'(hh >> FRAC_BITS);
    ff     = FRAC_BITS'(hh);
    p = frac_mul(v, FX_ONE - s);
    q = frac_mul(v, FX_ONE - frac_mul(s, IN_W'(ff)));
    t = frac_mul(v, FX_ONE - frac_mul(s, FX_ONE - IN_W'(ff)));
    case (sector)
      SEC_RED: begin
        r = v; g = t; b = p;
      end
      SEC_YELLOW: begin
        r = q; g = v; b = p;
      end
      SEC_GREEN: begin
        r = p; g = v; b = t;
      end
      SEC_CYAN: begin
        r = p; g = q; b = v;
      end
      SEC_BLUE: begin
        r = t; g = p; b = v;
      end
      default: begin
        r = v; g = p; b = q;
      end
    endcase
    res.red   = scale_255(r);
    res.green = scale_255(g);
    res.blue  = scale_255(b);
    return res;
  endfunction

  task automatic report(input string msg);
    $display("%0t hsv_rgb_checker: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    if (!rst_ni) begin
      rgb_pending.delete();
      pending_n <= 0;
    end else begin
      if (start_i === 1'b1 && busy_i === 1'b0) rgb_pending.push_back(convert_hsv(hsv_i));
      if (done_i !== 1'b0) begin
        if (rgb_pending.size() == 0) begin
          report($sformatf("result %h with no colour outstanding", rgb_i));
        end else begin
          want = rgb_pending.pop_front();
          if (rgb_i.red !== want.red)
            report($sformatf("red expected %0d got %0d", want.red, rgb_i.red));
          if (rgb_i.green !== want.green)
            report($sformatf("green expected %0d got %0d", want.green, rgb_i.green));
          if (rgb_i.blue !== want.blue)
            report($sformatf("blue expected %0d got %0d", want.blue, rgb_i.blue));
        end
      end
      pending_n <= rgb_pending.size();
    end
  end

endmodule

// File: test/tb_hsv_to_rgb_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hsv_to_rgb_converter
// Drives directed and random HSV colours into the converter with random
// gaps, bursts and two full drains, and leaves prediction and comparison to
// the checker beside the block.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter;
  import hsvrgb_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1330;
  localparam int unsigned SECTOR_STEP  = 10923;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  hsv_t hsv_i;
  logic busy_o;
  logic done_o;
  rgb_t rgb_o;
  int   pending;
  int   fail_count;
  bit   steady;

  hsv_to_rgb_converter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .hsv_i  (hsv_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rgb_o  (rgb_o)
  );

  hsv_rgb_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .hsv_i       (hsv_i),
    .busy_i      (busy_o),
    .done_i      (done_o),
    .rgb_i       (rgb_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("tb_hsv_to_rgb_converter: FAIL");
    $finish;
  end

  function automatic hsv_t make_hsv(input logic [IN_W-1:0] h, input logic [IN_W-1:0] s,
                                    input logic [IN_W-1:0] v);
    hsv_t c;
    c.hue        = h;
    c.saturation = s;
    c.brightness = v;
    return c;
  endfunction

  function automatic logic [IN_W-1:0] rand_frac();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return IN_W'(1);
        2:       return FX_ONE - IN_W'(1);
        default: return FX_ONE;
      endcase
    end
    if (k < 15) return IN_W'($urandom_range(int'(FX_ONE) + 1, (1 << IN_W) - 1));
    return IN_W'($urandom_range(0, int'(FX_ONE)));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned k;
    if (steady) return 0;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 88) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_colour(input hsv_t c);
    int unsigned gap;
    start_i <= 1'b1;
    hsv_i   <= c;
    @(posedge clk_i);
    while (busy_o !== 1'b0) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      hsv_i   <= make_hsv(IN_W'($urandom), IN_W'($urandom), IN_W'($urandom));
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    hsv_t c;
    int   k;
    start_i <= 1'b0;
    hsv_i   <= '0;
    rst_ni  <= 1'b0;
    steady  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    send_colour(make_hsv('0, '0, '0));
    send_colour(make_hsv('0, FX_ONE, FX_ONE));
    send_colour(make_hsv(FX_ONE, FX_ONE, FX_ONE));
    send_colour(make_hsv('1, '1, '1));
    send_colour(make_hsv(FX_ONE + IN_W'(1), FX_ONE + IN_W'(1), FX_ONE + IN_W'(1)));
    send_colour(make_hsv(IN_W'(12345), '0, FX_ONE));
    send_colour(make_hsv('1, '0, FX_ONE >> 1));
    send_colour(make_hsv(FX_ONE - IN_W'(1), '0, '1));
    for (k = 0; k < 6; k++)
      send_colour(make_hsv(IN_W'(int'(FX_ONE) * (2 * k + 1) / 12), FX_ONE, FX_ONE));
    send_colour(make_hsv(IN_W'(SECTOR_STEP - 1), FX_ONE, FX_ONE));
    send_colour(make_hsv(IN_W'(SECTOR_STEP), FX_ONE, FX_ONE));
    send_colour(make_hsv(FX_ONE - IN_W'(1), FX_ONE, FX_ONE));
    send_colour(make_hsv(IN_W'(30000), FX_ONE, '0));
    send_colour(make_hsv(IN_W'(50000), IN_W'(1), FX_ONE));
    send_colour(make_hsv(IN_W'(40000), FX_ONE >> 1, FX_ONE - IN_W'(1)));
    send_colour(make_hsv(IN_W'(20000), FX_ONE - IN_W'(1), IN_W'(1)));

    for (k = 0; k < RANDOM_BEATS; k++) begin
      if (k % 100 == 0) steady = ($urandom_range(0, 2) == 0);
      if (k == RANDOM_BEATS / 2) drain();
      c = make_hsv(rand_frac(), rand_frac(), rand_frac());
      case ($urandom_range(0, 19))
        0: c.saturation = '0;
        1, 2: c.hue = IN_W'($urandom_range(0, 6) * SECTOR_STEP + $urandom_range(0, 3));
        default: ;
      endcase
      send_colour(c);
    end

    drain();
    repeat (12) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_hsv_to_rgb_converter: PASS");
    end else begin
      $display("tb_hsv_to_rgb_converter: FAIL");
    end
    $finish;
  end

endmodule
